FILE: rtl/rsti_pkg.sv
// Shared types, constants and the front-to-back command format for the
// radix string-to-integer parser. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package rsti_pkg;

  // Field widths fixed by the interface.
  localparam int CH_W     = 8;
  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 16;
  localparam int BASE_W   = 5;
  localparam int DIGIT_W  = 4;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // Characters of interest.
  localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_LA   = 8'h61;
  localparam logic [CH_W-1:0] CH_LF   = 8'h66;
  localparam logic [CH_W-1:0] CH_UA   = 8'h41;
  localparam logic [CH_W-1:0] CH_UF   = 8'h46;
  localparam logic [CH_W-1:0] CH_LX   = 8'h78;
  localparam logic [CH_W-1:0] CH_UX   = 8'h58;

  // Bases.
  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  // Digit value that marks a character which is no digit in any base.
  localparam logic [BASE_W-1:0] DIGIT_NONE = 5'd16;

  // Parse phase kept by the front.
  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_ZERO_X,
    PH_DIGITS
  } phase_t;

  // Operation the back carries out.
  typedef enum logic {
    CMD_DIGIT,
    CMD_FINISH
  } cmd_op_t;

  // One command: a digit to accumulate, or the end of a parse.
  typedef struct packed {
    cmd_op_t               op;
    logic [DIGIT_W-1:0]    digit;
    logic [BASE_W-1:0]     base;
    logic [OFFSET_W-1:0]   count;
  } cmd_t;

endpackage

FILE: rtl/rsti_ifs.sv
// Channel interfaces of the radix string-to-integer parser: the character
// input and the result output. Depends on rsti_pkg for field widths.
`timescale 1ns / 1ps

interface rsti_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsti_pkg::CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface rsti_out_if;
  logic                          valid;
  logic                          ready;
  logic [rsti_pkg::VALUE_W-1:0]  value;
  logic [rsti_pkg::OFFSET_W-1:0] end_offset;
  logic [rsti_pkg::BASE_W-1:0]   base_used;

  modport source (output valid, output value, output end_offset, output base_used,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input base_used,
                  output ready);
endinterface

FILE: rtl/rsti_front.sv
// Front part of the parser: accepts characters, tracks prefix and base and
// issues digit and finish commands. Depends on rsti_pkg and rsti_ifs.
`timescale 1ns / 1ps

module rsti_front (
  input  logic                          clk,
  input  logic                          rst_n,
  rsti_in_if.sink                       in_ch,
  input  logic                          cfg_we,
  input  logic [rsti_pkg::BASE_W-1:0]   cfg_wdata,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output rsti_pkg::cmd_t                cmd_data
);

  // Digit value of a character, or the no-digit mark.
  function automatic logic [rsti_pkg::BASE_W-1:0] digit_of(
    input logic [rsti_pkg::CH_W-1:0] c
  );
    logic [rsti_pkg::CH_W-1:0] diff;
    diff = '0;
    if (c >= rsti_pkg::CH_ZERO && c <= rsti_pkg::CH_NINE) begin
      diff = c - rsti_pkg::CH_ZERO;
    end else if (c >= rsti_pkg::CH_LA && c <= rsti_pkg::CH_LF) begin
      diff = c - rsti_pkg::CH_LA + 8'd10;
    end else if (c >= rsti_pkg::CH_UA && c <= rsti_pkg::CH_UF) begin
      diff = c - rsti_pkg::CH_UA + 8'd10;
    end else begin
      diff = {3'b000, rsti_pkg::DIGIT_NONE};
    end
    return diff[rsti_pkg::BASE_W-1:0];
  endfunction

  // Base from the radix register, with the automatic default.
  function automatic logic [rsti_pkg::BASE_W-1:0] pick_base(
    input logic [rsti_pkg::BASE_W-1:0] rad,
    input logic [rsti_pkg::BASE_W-1:0] dflt
  );
    logic [rsti_pkg::BASE_W-1:0] b;
    if (rad == rsti_pkg::BASE_AUTO) begin
      b = dflt;
    end else if (rad > rsti_pkg::BASE_HEX) begin
      b = rsti_pkg::BASE_HEX;
    end else begin
      b = rad;
    end
    return b;
  endfunction

  logic [rsti_pkg::BASE_W-1:0]   radix_r;
  rsti_pkg::phase_t              phase_r, phase_nxt;
  logic [rsti_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [rsti_pkg::OFFSET_W-1:0] count_r, count_nxt;

  logic                          accept;
  logic [rsti_pkg::BASE_W-1:0]   dig;
  logic                          is_x;
  logic                          hold;
  logic                          use_feed;
  logic                          feed_ok;
  logic [rsti_pkg::BASE_W-1:0]   sel_base;
  logic [rsti_pkg::OFFSET_W-1:0] cnt_base;
  logic [rsti_pkg::OFFSET_W-1:0] cnt_inc;

  assign in_ch.ready = !cmd_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Radix register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rsti_pkg::BASE_AUTO;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Classify the character against the current phase.
  always_comb begin
    dig      = digit_of(in_ch.ch);
    is_x     = (in_ch.ch == rsti_pkg::CH_LX) || (in_ch.ch == rsti_pkg::CH_UX);
    hold     = 1'b0;
    use_feed = 1'b0;
    sel_base = base_r;
    cnt_base = count_r;
    unique case (phase_r)
      rsti_pkg::PH_START: begin
        if (in_ch.ch == rsti_pkg::CH_ZERO) begin
          hold = 1'b1;
        end else begin
          sel_base = pick_base(radix_r, rsti_pkg::BASE_DEC);
          cnt_base = '0;
          use_feed = 1'b1;
        end
      end
      rsti_pkg::PH_ZERO: begin
        if (is_x) begin
          hold = 1'b1;
        end else begin
          // The held zero counts as one digit of an octal (or chosen) base.
          sel_base = pick_base(radix_r, rsti_pkg::BASE_OCT);
          cnt_base = 16'd1;
          use_feed = 1'b1;
        end
      end
      rsti_pkg::PH_ZERO_X: begin
        if (dig != rsti_pkg::DIGIT_NONE) begin
          sel_base = pick_base(radix_r, rsti_pkg::BASE_HEX);
          cnt_base = 16'd2;
          use_feed = 1'b1;
        end else begin
          // Rejected prefix: stop at the x, drop this character.
          sel_base = pick_base(radix_r, rsti_pkg::BASE_OCT);
          cnt_base = 16'd1;
        end
      end
      rsti_pkg::PH_DIGITS: begin
        use_feed = 1'b1;
      end
      default: begin
        use_feed = 1'b0;
      end
    endcase
    feed_ok = use_feed && (in_ch.ch != rsti_pkg::CH_NUL) && (dig < sel_base);
    cnt_inc = (cnt_base == rsti_pkg::OFFSET_MAX) ? cnt_base : cnt_base + 16'd1;
  end

  // Next phase, base and count.
  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    count_nxt = count_r;
    if (accept) begin
      if (hold) begin
        phase_nxt = (phase_r == rsti_pkg::PH_START) ? rsti_pkg::PH_ZERO
                                                    : rsti_pkg::PH_ZERO_X;
      end else if (feed_ok) begin
        phase_nxt = rsti_pkg::PH_DIGITS;
        base_nxt  = sel_base;
        count_nxt = cnt_inc;
      end else begin
        phase_nxt = rsti_pkg::PH_START;
        base_nxt  = rsti_pkg::BASE_AUTO;
        count_nxt = '0;
      end
    end
  end

  // Command towards the back.
  always_comb begin
    cmd_push       = accept && !hold;
    cmd_data.op    = feed_ok ? rsti_pkg::CMD_DIGIT : rsti_pkg::CMD_FINISH;
    cmd_data.digit = dig[rsti_pkg::DIGIT_W-1:0];
    cmd_data.base  = sel_base;
    cmd_data.count = cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rsti_pkg::PH_START;
      base_r  <= rsti_pkg::BASE_AUTO;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A finish always returns the front to the start of a new string.
  a_finish_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd_data.op == rsti_pkg::CMD_FINISH |=>
      phase_r == rsti_pkg::PH_START && count_r == '0)
    else $error("front did not restart after a finish");

  // A digit command carries a digit below a real base.
  a_digit_in_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd_data.op == rsti_pkg::CMD_DIGIT |->
      cmd_data.base != rsti_pkg::BASE_AUTO && {1'b0, cmd_data.digit} < cmd_data.base)
    else $error("digit command outside its base");
`endif

endmodule

FILE: rtl/rsti_cmd_fifo.sv
// Short command queue between the parser front and back.
// Depends on rsti_pkg for the command type and depth.
`timescale 1ns / 1ps

module rsti_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsti_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rsti_pkg::cmd_t head
);

  localparam int PTR_W = (rsti_pkg::CMD_DEPTH > 1) ? $clog2(rsti_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(rsti_pkg::CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rsti_pkg::CMD_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rsti_pkg::CMD_DEPTH);

  rsti_pkg::cmd_t   slot_r [rsti_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("command queue underflow");
`endif

endmodule

FILE: rtl/rsti_back.sv
// Back part of the parser: runs the multiply-add accumulator and holds the
// result register. Depends on rsti_pkg and rsti_ifs.
`timescale 1ns / 1ps

module rsti_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  rsti_pkg::cmd_t cmd_head,
  output logic           cmd_pop,
  rsti_out_if.source     out_res
);

  logic [rsti_pkg::VALUE_W-1:0]  acc_r, acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rsti_pkg::VALUE_W-1:0]  value_r;
  logic [rsti_pkg::OFFSET_W-1:0] offset_r;
  logic [rsti_pkg::BASE_W-1:0]   base_used_r;
  logic                          slot_free;
  logic                          do_finish;
  logic [rsti_pkg::VALUE_W-1:0]  product;

  assign out_res.valid      = out_valid_r;
  assign out_res.value      = value_r;
  assign out_res.end_offset = offset_r;
  assign out_res.base_used  = base_used_r;

  // A digit never waits; a finish waits for the result register.
  assign slot_free = !out_valid_r || out_res.ready;
  assign cmd_pop   = cmd_valid && (cmd_head.op == rsti_pkg::CMD_DIGIT || slot_free);
  assign do_finish = cmd_pop && cmd_head.op == rsti_pkg::CMD_FINISH;

  // Accumulate value*base+digit, wrapping at the word width.
  always_comb begin
    product       = acc_r * {{(rsti_pkg::VALUE_W-rsti_pkg::BASE_W){1'b0}}, cmd_head.base};
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd_pop) begin
      if (cmd_head.op == rsti_pkg::CMD_DIGIT) begin
        acc_nxt = product +
                  {{(rsti_pkg::VALUE_W-rsti_pkg::DIGIT_W){1'b0}}, cmd_head.digit};
      end else begin
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on a finish.
  always_ff @(posedge clk) begin
    if (do_finish) begin
      value_r     <= acc_r;
      offset_r    <= cmd_head.count;
      base_used_r <= cmd_head.base;
    end
  end

`ifndef NO_ASSERTIONS
  // A finish presents a result and starts the next value from zero.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    do_finish |=> out_valid_r && acc_r == '0)
    else $error("finish did not load the result");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res.ready |-> !do_finish)
    else $error("result overwritten before transfer");
`endif

endmodule

FILE: rtl/radix_string_to_integer.sv
// Top level of the radix string-to-integer parser: joins front, command
// queue and back. Depends on rsti_pkg, rsti_ifs and the three sub-modules.
`timescale 1ns / 1ps

// The block takes one character per transfer and sustains one character per
// clock cycle while the command queue has room. A NUL or the first character
// that is not a digit of the base ends the parse and yields one result (value,
// end offset, base used), which waits in an output register while further
// characters are taken. The front decides prefix and base from the character
// alone, so nothing loops back from the accumulator; the cycle time is set by
// the 64 by 5 bit multiply-add in the back. The two-entry command queue lets
// the front keep accepting while a finished result waits to be taken. Write
// radix only while the block is idle; a value of 0 selects automatic
// detection of decimal, octal or hex.

module radix_string_to_integer (
  input  logic                        clk,
  input  logic                        rst_n,
  rsti_in_if.sink                     in_ch,
  rsti_out_if.source                  out_res,
  input  logic                        cfg_we,
  input  logic [rsti_pkg::BASE_W-1:0] cfg_wdata
);

  logic           cmd_push;
  rsti_pkg::cmd_t cmd_data;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_valid;
  rsti_pkg::cmd_t cmd_head;

  // Character classification and base tracking.
  rsti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data)
  );

  // Decoupling queue.
  rsti_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .head      (cmd_head)
  );

  // Accumulation and result register.
  rsti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_res   (out_res)
  );

endmodule
